// ----- hdl/upd_pkg.sv -----
// Package for the URL percent-escape decoder.
// Character codes, escape phase codes and hex digit helpers; no dependencies.
package upd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned MaxRes = 3;
  localparam int unsigned CntW = $clog2(MaxRes + 1);

  localparam logic [ByteW-1:0] PctChar   = 8'h25;
  localparam logic [ByteW-1:0] PlusChar  = 8'h2B;
  localparam logic [ByteW-1:0] SpaceChar = 8'h20;

  localparam logic [1:0] PhIdle  = 2'd0;
  localparam logic [1:0] PhPct   = 2'd1;
  localparam logic [1:0] PhDigit = 2'd2;

  // uppercase hex only
  function automatic logic is_hex(input logic [ByteW-1:0] b);
    return ((b >= 8'h30) && (b <= 8'h39)) || ((b >= 8'h41) && (b <= 8'h46));
  endfunction

  function automatic logic [3:0] hex_val(input logic [ByteW-1:0] b);
    logic [3:0] v;
    if ((b >= 8'h30) && (b <= 8'h39)) begin
      v = b[3:0];
    end else if ((b >= 8'h41) && (b <= 8'h46)) begin
      v = b[3:0] + 4'd9;
    end else begin
      v = 4'd0;
    end
    return v;
  endfunction

endpackage

// ----- hdl/url_percent_decoder_core.sv -----
// Top level of the URL percent-escape decoder: escape state and result buffer.
// Depends on upd_pkg.
//
// Decodes a byte stream one byte per transfer: '+' becomes a space, '%' with two
// uppercase hex digits becomes one byte, and a broken or cut-off escape is passed
// on as a literal '%' (and held digit) before the offending byte is decoded again.
// Each input transfer yields zero to three output transfers; its results are
// registered together in a three-entry buffer that drains one byte per cycle while
// m_axis_tready is high; an input is accepted whenever the buffer is empty or its
// last entry leaves in the same cycle. Sustained rate is one input per cycle while
// each input makes at most one byte and the output is ready; an input making more
// bytes holds off the next input until its last byte leaves. Output tlast marks the
// last byte caused by an input, tuser marks the final byte of a string.
module url_percent_decoder_core
  import upd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [ByteW-1:0] s_axis_tdata,  // [7:0] in_byte
  input  logic             s_axis_tlast,  // is_last
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [ByteW-1:0] m_axis_tdata,  // [7:0] out_byte
  output logic             m_axis_tlast,  // run_last
  output logic             m_axis_tuser   // [0] string_end
);

  logic [1:0]       phase_q, phase_d;
  logic [ByteW-1:0] held_q, held_d;

  logic [ByteW-1:0] res_q [MaxRes];
  logic [ByteW-1:0] res_d [MaxRes];
  logic [CntW-1:0]  rem_q, cnt_d;
  logic             end_q;

  logic in_xfer, out_xfer;

  assign m_axis_tvalid = (rem_q != '0);
  assign m_axis_tdata  = res_q[0];
  assign m_axis_tlast  = (rem_q == CntW'(1));
  assign m_axis_tuser  = (rem_q == CntW'(1)) && end_q;

  assign out_xfer      = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (rem_q == '0) || ((rem_q == CntW'(1)) && m_axis_tready);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // decode one input byte against the escape state
  always_comb begin
    logic [ByteW-1:0] b;
    logic             redo;
    b       = s_axis_tdata;
    redo    = 1'b0;
    cnt_d   = '0;
    phase_d = phase_q;
    held_d  = held_q;
    for (int i = 0; i < MaxRes; i++) begin
      res_d[i] = '0;
    end

    unique case (phase_q)
      PhPct: begin
        if (is_hex(b)) begin
          held_d  = b;
          phase_d = PhDigit;
        end else begin
          res_d[cnt_d[1:0]] = PctChar;
          cnt_d   = cnt_d + CntW'(1);
          phase_d = PhIdle;
          redo    = 1'b1;
        end
      end
      PhDigit: begin
        phase_d = PhIdle;
        if (is_hex(b)) begin
          res_d[cnt_d[1:0]] = {hex_val(held_q), hex_val(b)};
          cnt_d = cnt_d + CntW'(1);
        end else begin
          res_d[0] = PctChar;
          res_d[1] = held_q;
          cnt_d    = CntW'(2);
          redo     = 1'b1;
        end
      end
      default: begin
        phase_d = PhIdle;
        redo    = 1'b1;
      end
    endcase

    if (redo) begin
      if (b == PctChar) begin
        phase_d = PhPct;
      end else begin
        res_d[cnt_d[1:0]] = (b == PlusChar) ? SpaceChar : b;
        cnt_d = cnt_d + CntW'(1);
      end
    end

    // flush an open escape at end of string
    if (s_axis_tlast) begin
      if (phase_d == PhPct) begin
        res_d[cnt_d[1:0]] = PctChar;
        cnt_d = cnt_d + CntW'(1);
      end else if (phase_d == PhDigit) begin
        res_d[cnt_d[1:0]] = PctChar;
        cnt_d = cnt_d + CntW'(1);
        res_d[cnt_d[1:0]] = held_d;
        cnt_d = cnt_d + CntW'(1);
      end
      phase_d = PhIdle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      held_q  <= '0;
      rem_q   <= '0;
      end_q   <= 1'b0;
    end else begin
      if (in_xfer) begin
        phase_q <= phase_d;
        held_q  <= held_d;
        rem_q   <= cnt_d;
        end_q   <= s_axis_tlast;
      end else if (out_xfer) begin
        rem_q <= rem_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      for (int i = 0; i < MaxRes; i++) begin
        res_q[i] <= res_d[i];
      end
    end else if (out_xfer) begin
      for (int i = 0; i < MaxRes - 1; i++) begin
        res_q[i] <= res_q[i+1];
      end
    end
  end

endmodule
